// ===== rtl/fcnwe_pkg.sv =====
// Shared types, constants and the rank lookup function for the front-coded
// nibble word encoder. No dependencies.
`timescale 1ns / 1ps

package fcnwe_pkg;

  localparam int CHAR_W          = 8;
  localparam int NIB_W           = 4;
  localparam int CODES_PER_LEVEL = 13;
  localparam int NUM_LEVELS      = 3;
  localparam int NUM_RANKS       = NUM_LEVELS * CODES_PER_LEVEL;
  localparam int MAX_BURST       = 6;
  localparam int BURST_CW        = 3;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int TOP_REG_W       = 56;
  localparam int SHARED_W        = 4;

  // Code nibbles.
  localparam logic [NIB_W-1:0] NIB_FULL_WORD = 4'h0;
  localparam logic [NIB_W-1:0] NIB_ESC_1     = 4'hD;
  localparam logic [NIB_W-1:0] NIB_ESC_2     = 4'hE;
  localparam logic [NIB_W-1:0] NIB_END       = 4'hF;
  localparam logic [NIB_W-1:0] NIB_ERROR     = 4'h0;

  // Fewest shared characters that are worth a count nibble.
  localparam logic [SHARED_W-1:0] MIN_SHARED = 4'd2;

  // Escape levels of a rank.
  localparam logic [1:0] LVL_BARE  = 2'd0;
  localparam logic [1:0] LVL_ESC_1 = 2'd1;
  localparam logic [1:0] LVL_ESC_2 = 2'd2;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNKNOWN  = 2'd1,
    ERR_TOO_LONG = 2'd2
  } err_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANK_0 = 3'd0,
    CFG_RANK_1 = 3'd1,
    CFG_RANK_2 = 3'd2,
    CFG_RANK_3 = 3'd3,
    CFG_RANK_4 = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] level;
    logic [3:0] index;
  } rank_hit_t;

  typedef struct packed {
    logic [NIB_W-1:0] nibble;
    err_code_t        err;
  } burst_entry_t;

  // All nibbles that one item causes, handed to the output queue at once.
  typedef struct packed {
    logic                            valid;
    logic [BURST_CW-1:0]             count;
    burst_entry_t [MAX_BURST-1:0]    ents;
  } burst_load_t;

  // The highest rank that holds the byte wins.
  function automatic rank_hit_t find_rank(input logic [NUM_RANKS*CHAR_W-1:0] chars,
                                          input logic [CHAR_W-1:0]           ch);
    rank_hit_t res;
    res = '0;
    for (int lv = 0; lv < NUM_LEVELS; lv++) begin
      for (int ix = 0; ix < CODES_PER_LEVEL; ix++) begin
        if (chars[(lv*CODES_PER_LEVEL + ix)*CHAR_W +: CHAR_W] == ch) begin
          res.hit   = 1'b1;
          res.level = 2'(lv);
          res.index = 4'(ix);
        end
      end
    end
    return res;
  endfunction

  function automatic logic [NIB_W-1:0] level_escape(input logic [1:0] level);
    return (level == LVL_ESC_2) ? NIB_ESC_2 : NIB_ESC_1;
  endfunction

endpackage

// ===== rtl/fcnwe_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fcnwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fcnwe_ranks.sv =====
// Rank character registers written through the configuration port, and
// the two rank lookups of the coder. Depends on fcnwe_pkg.
`timescale 1ns / 1ps

module fcnwe_ranks
  import fcnwe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CHAR_W-1:0]     look_char,
  input  logic [CHAR_W-1:0]     look_held,
  output rank_hit_t             hit_char,
  output rank_hit_t             hit_held
);

  logic [CFG_DATA_W-1:0]       rank_lo [4];
  logic [TOP_REG_W-1:0]        rank_hi;
  logic [NUM_RANKS*CHAR_W-1:0] chars;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        rank_lo[i] <= '0;
      end
      rank_hi <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RANK_0: rank_lo[0] <= cfg_data;
        CFG_RANK_1: rank_lo[1] <= cfg_data;
        CFG_RANK_2: rank_lo[2] <= cfg_data;
        CFG_RANK_3: rank_lo[3] <= cfg_data;
        CFG_RANK_4: rank_hi    <= cfg_data[TOP_REG_W-1:0];
        default:    ;
      endcase
    end
  end

  assign chars    = {rank_hi, rank_lo[3], rank_lo[2], rank_lo[1], rank_lo[0]};
  assign hit_char = find_rank(chars, look_char);
  assign hit_held = find_rank(chars, look_held);

endmodule

// ===== rtl/fcnwe_coder.sv =====
// Word state, previous-word memory with forwarding, and the per-item coding
// decision. Depends on fcnwe_pkg and fcnwe_ram.
`timescale 1ns / 1ps

module fcnwe_coder
  import fcnwe_pkg::*;
#(
  parameter int MAX_WORD_CHARS    = 64,
  parameter int MAX_SHARED_PREFIX = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [CHAR_W-1:0] s_tdata,
  input  logic              s_tlast,
  output logic [CHAR_W-1:0] look_char,
  output logic [CHAR_W-1:0] look_held,
  input  rank_hit_t         hit_char,
  input  rank_hit_t         hit_held,
  input  logic              burst_ready,
  output burst_load_t       load
);

  localparam int PW = $clog2(MAX_WORD_CHARS + 1);
  localparam int AW = (MAX_WORD_CHARS > 1) ? $clog2(MAX_WORD_CHARS) : 1;
  localparam logic [PW-1:0]       POS_MAX = PW'(MAX_WORD_CHARS);
  localparam logic [SHARED_W-1:0] MSP     = SHARED_W'(MAX_SHARED_PREFIX);

  // Fetch side: the position of the next item, known at acceptance.
  logic [PW-1:0] fpos;
  logic          accept;

  // Item waiting for its memory data.
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_end;
  logic [PW-1:0]     s1_pos;

  logic              fwd_hit;
  logic [CHAR_W-1:0] fwd_data;
  logic [CHAR_W-1:0] ram_rdata;
  logic [CHAR_W-1:0] mem_data;

  // Word state.
  logic [PW-1:0]       prior_length, prior_length_next;
  logic [SHARED_W-1:0] shared_count, shared_count_next;
  logic                still_matching, still_matching_next;
  logic [CHAR_W-1:0]   held_char, held_char_next;
  logic                held_valid, held_valid_next;
  logic                discarding, discarding_next;

  logic                commit;
  logic                wr_en;
  logic                match;
  logic                need_held;
  logic                start_word;
  err_code_t           err;
  logic [SHARED_W-1:0] sc_inc;
  logic                hdr_en;
  logic [NIB_W-1:0]    hdr_nib;
  logic                held_en;
  logic                chr_en;
  logic [BURST_CW-1:0] n;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !s1_valid || commit;
  assign commit   = s1_valid && (burst_ready || (load.count == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      fpos <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        fpos <= '0;
      end else if (fpos != POS_MAX) begin
        fpos <= fpos + PW'(1);
      end
    end
  end

  fcnwe_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_WORD_CHARS)
  ) u_prior_word (
    .clk   (clk),
    .we    (commit && wr_en),
    .waddr (s1_pos[AW-1:0]),
    .wdata (s1_char),
    .re    (accept),
    .raddr (fpos[AW-1:0]),
    .rdata (ram_rdata)
  );

  // A one-character word followed at once by the next word reads the
  // entry that is being written in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= commit && wr_en && (s1_pos[AW-1:0] == fpos[AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= s1_char;
      s1_char  <= s_tdata;
      s1_end   <= s_tlast;
      s1_pos   <= fpos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  assign mem_data  = fwd_hit ? fwd_data : ram_rdata;
  assign look_char = s1_char;
  assign look_held = held_char;

  always_comb begin
    prior_length_next   = prior_length;
    shared_count_next   = shared_count;
    still_matching_next = still_matching;
    held_char_next      = held_char;
    held_valid_next     = held_valid;
    discarding_next     = discarding;
    start_word          = 1'b0;
    wr_en               = 1'b0;
    hdr_en              = 1'b0;
    hdr_nib             = NIB_FULL_WORD;
    held_en             = 1'b0;
    chr_en              = 1'b0;
    load                = '0;
    n                   = '0;
    sc_inc              = shared_count + SHARED_W'(1);

    match = still_matching && (s1_pos < prior_length) && (mem_data == s1_char) &&
            (shared_count < MSP);
    need_held = still_matching && !match && (shared_count < MIN_SHARED) && held_valid;

    if (s1_pos >= POS_MAX) begin
      err = ERR_TOO_LONG;
    end else if (!hit_char.hit || (need_held && !hit_held.hit)) begin
      err = ERR_UNKNOWN;
    end else begin
      err = ERR_NONE;
    end

    if (discarding) begin
      if (s1_end) begin
        discarding_next = 1'b0;
        start_word      = 1'b1;
      end
    end else if (err != ERR_NONE) begin
      load.ents[0].nibble = NIB_ERROR;
      load.ents[0].err    = err;
      n                   = BURST_CW'(1);
      prior_length_next   = '0;
      start_word          = 1'b1;
      discarding_next     = !s1_end;
    end else begin
      wr_en = 1'b1;
      if (match) begin
        shared_count_next = sc_inc;
        if (s1_pos == '0) begin
          held_char_next  = s1_char;
          held_valid_next = 1'b1;
        end
        if (sc_inc >= MSP) begin
          // The count is capped: give it now and code the rest in full.
          hdr_en              = 1'b1;
          hdr_nib             = sc_inc;
          still_matching_next = 1'b0;
        end else if (s1_end) begin
          hdr_en = 1'b1;
          if (sc_inc >= MIN_SHARED) begin
            hdr_nib = sc_inc;
          end else begin
            chr_en = 1'b1;
          end
        end
      end else if (still_matching) begin
        still_matching_next = 1'b0;
        hdr_en              = 1'b1;
        if (shared_count >= MIN_SHARED) begin
          hdr_nib = shared_count;
        end else begin
          held_en = held_valid;
        end
        chr_en = 1'b1;
      end else begin
        chr_en = 1'b1;
      end

      if (hdr_en) begin
        load.ents[n].nibble = hdr_nib;
        n = n + BURST_CW'(1);
      end
      if (held_en) begin
        if (hit_held.level != LVL_BARE) begin
          load.ents[n].nibble = level_escape(hit_held.level);
          n = n + BURST_CW'(1);
        end
        load.ents[n].nibble = hit_held.index;
        n = n + BURST_CW'(1);
      end
      if (chr_en) begin
        if (hit_char.level != LVL_BARE) begin
          load.ents[n].nibble = level_escape(hit_char.level);
          n = n + BURST_CW'(1);
        end
        load.ents[n].nibble = hit_char.index;
        n = n + BURST_CW'(1);
      end
      if (s1_end) begin
        load.ents[n].nibble = NIB_END;
        n = n + BURST_CW'(1);
        prior_length_next = s1_pos + PW'(1);
        start_word        = 1'b1;
      end
    end

    if (start_word) begin
      shared_count_next   = '0;
      still_matching_next = 1'b1;
      held_valid_next     = 1'b0;
    end

    // An item with nibbles commits only when the queue can take them.
    load.count = n;
    load.valid = s1_valid && burst_ready && (n != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_length   <= '0;
      shared_count   <= '0;
      still_matching <= 1'b1;
      held_valid     <= 1'b0;
      discarding     <= 1'b0;
    end else if (commit) begin
      prior_length   <= prior_length_next;
      shared_count   <= shared_count_next;
      still_matching <= still_matching_next;
      held_valid     <= held_valid_next;
      discarding     <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      held_char <= held_char_next;
    end
  end

`ifndef SYNTH
  a_error_single: assert property (@(posedge clk) disable iff (rst)
    commit && !discarding && (err != ERR_NONE) |-> (load.count == BURST_CW'(1)))
    else $error("error item must give exactly one result");

  a_shared_cap: assert property (@(posedge clk) disable iff (rst)
    shared_count <= MSP)
    else $error("shared count above its cap");

  a_word_restart: assert property (@(posedge clk) disable iff (rst)
    commit && s1_end |=> (shared_count == '0) && still_matching && !held_valid &&
                         !discarding)
    else $error("word state not restarted after a word end");
`endif

endmodule

// ===== rtl/fcnwe_burst.sv =====
// Output queue: holds the nibbles of one item and hands them out one per
// cycle while m_tready allows, through an output register. Depends on fcnwe_pkg.
`timescale 1ns / 1ps

module fcnwe_burst
  import fcnwe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  burst_load_t      load,
  output logic             burst_ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [NIB_W-1:0] nibble,
  output logic             last_of_run,
  output err_code_t        error_code
);

  logic [BURST_CW-1:0]          cnt;
  burst_entry_t [MAX_BURST-1:0] ents;
  logic                         pop;

  assign pop         = (cnt != '0) && (!m_tvalid || m_tready);
  assign burst_ready = (cnt == '0) || ((cnt == BURST_CW'(1)) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load.valid) begin
      cnt <= load.count;
    end else if (pop) begin
      cnt <= cnt - BURST_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      ents <= load.ents;
    end else if (pop) begin
      for (int i = 0; i < MAX_BURST - 1; i++) begin
        ents[i] <= ents[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      nibble      <= ents[0].nibble;
      error_code  <= ents[0].err;
      last_of_run <= (cnt == BURST_CW'(1));
    end
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= BURST_CW'(MAX_BURST))
    else $error("output queue count out of range");
`endif

endmodule

// ===== rtl/front_coded_nibble_word_encoder_top.sv =====
// Front-coded nibble word encoder, top level: rank registers, coder with the
// previous-word RAM, and the output queue. Depends on fcnwe_pkg and all fcnwe_ modules.
// An accepted item waits in the coder stage register; its nibbles are loaded into
// the output queue at once and leave through the output register, one per cycle while
// m_tready allows. Items giving at most one nibble are taken one per cycle while the
// output is not stalled; an item giving more holds the input until the queue drains.
`timescale 1ns / 1ps

// Reset is synchronous and active high. It clears the rank registers, the word
// state and all valid flags. The previous-word RAM is not cleared: an entry is
// only read below the stored previous length, so it is always written before use,
// and the block accepts items in the first cycle after reset.
//
// Structure: the position of each item is known when it is accepted, so the
// previous-word RAM is read at acceptance and its data is ready the next cycle.
// The coder then decides all nibbles of the item at once, writes a coded character
// back to the RAM and updates the word state. A one-character word followed
// directly by another word reads the entry being written in that same cycle;
// a forwarding register supplies the new byte in that case.

module front_coded_nibble_word_encoder_top
  import fcnwe_pkg::*;
#(
  parameter int MAX_WORD_CHARS    = 64,
  parameter int MAX_SHARED_PREFIX = 15
) (
  input  logic                  clk,
  input  logic                  rst,
  // Input items.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,    // [7:0] character
  input  logic                  s_tlast,    // word_end
  // Result items.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,    // [3:0] nibble, [7:4] zero
  output logic                  m_tlast,    // last_of_run
  output logic [1:0]            m_tuser,    // [1:0] error_code
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CHAR_W-1:0] look_char;
  logic [CHAR_W-1:0] look_held;
  rank_hit_t         hit_char;
  rank_hit_t         hit_held;
  logic              burst_ready;
  burst_load_t       load;
  logic [NIB_W-1:0]  nibble;
  err_code_t         error_code;

  // Two lookups per item: the current character, and the character held back
  // while the word still matched the previous one.
  fcnwe_ranks u_ranks (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .look_char (look_char),
    .look_held (look_held),
    .hit_char  (hit_char),
    .hit_held  (hit_held)
  );

  fcnwe_coder #(
    .MAX_WORD_CHARS    (MAX_WORD_CHARS),
    .MAX_SHARED_PREFIX (MAX_SHARED_PREFIX)
  ) u_coder (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .look_char   (look_char),
    .look_held   (look_held),
    .hit_char    (hit_char),
    .hit_held    (hit_held),
    .burst_ready (burst_ready),
    .load        (load)
  );

  // Up to six nibbles per item wait here while the next item is fetched.
  fcnwe_burst u_burst (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .burst_ready (burst_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .nibble      (nibble),
    .last_of_run (m_tlast),
    .error_code  (error_code)
  );

  assign m_tdata = {{(8 - NIB_W){1'b0}}, nibble};
  assign m_tuser = error_code;

endmodule
